// ===== rtl/csem_pkg.sv =====
package csem_pkg;

	localparam int NUM_SEMS_DEF    = 16;
	localparam int MAX_WAITERS_DEF = 16;
	localparam int PID_BITS_DEF    = 8;

	// signed semaphore count
	localparam int CNT_W = 16;
	localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sh7FFF;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_WAIT   = 2'd1;
	localparam logic [1:0] KIND_SIGNAL = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_FREE = 2'd1;
	localparam logic [1:0] STATUS_Q_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/csem_ctrl.sv =====
module csem_ctrl import csem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				// wait for room in the result register
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/csem_datapath.sv =====
module csem_datapath import csem_pkg::*; #(
	parameter int NUM_SEMS    = NUM_SEMS_DEF,
	parameter int MAX_WAITERS = MAX_WAITERS_DEF,
	parameter int PID_BITS    = PID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  kind,
	input  logic [7:0]  process,
	input  logic [3:0]  sem_index,
	input  logic [14:0] init_value,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [3:0]  sem_id,
	output logic        block_caller,
	output logic        wake_valid,
	output logic [7:0]  wake_process
);

	localparam int SEM_W      = $clog2(NUM_SEMS);
	localparam int ACNT_W     = $clog2(NUM_SEMS + 1);
	localparam int Q_W        = $clog2(MAX_WAITERS);
	localparam int REC_DEPTH  = 2 ** SEM_W;
	localparam int RING_DEPTH = 2 ** (SEM_W + Q_W);
	localparam logic signed [CNT_W-1:0] CNT_FLOOR = CNT_W'(-MAX_WAITERS);
	localparam logic [Q_W-1:0] PTR_LAST = Q_W'(MAX_WAITERS - 1);

	typedef struct packed {
		logic signed [CNT_W-1:0] count;
		logic [Q_W-1:0]          head;
		logic [Q_W-1:0]          tail;
	} rec_t;

	function automatic logic [Q_W-1:0] ptr_next(input logic [Q_W-1:0] ptr);
		ptr_next = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
	endfunction

	// request registers
	logic [1:0]          kind_q;
	logic [PID_BITS-1:0] proc_q;
	logic [SEM_W-1:0]    addr_q;
	logic [14:0]         init_q;
	logic                in_range_q;

	// entries are never released, so the used ones are exactly those below the count
	logic [ACNT_W-1:0]   alloc_cnt_q;

	rec_t                rec_mem [REC_DEPTH];
	rec_t                rec_rd_q;
	logic [PID_BITS-1:0] ring_mem [RING_DEPTH];
	logic [PID_BITS-1:0] ring_rd_q;

	logic [1:0] res_status_q;
	logic [3:0] res_id_q;
	logic       res_block_q;
	logic       res_wake_q;

	logic       out_valid_q;
	logic [1:0] status_q;
	logic [3:0] sem_id_q;
	logic       block_q;
	logic       wake_q;
	logic [7:0] wake_proc_q;

	logic                    alloc_full;
	logic                    entry_live;
	logic signed [CNT_W-1:0] cnt_dec;
	logic signed [CNT_W-1:0] cnt_inc;
	logic                    rec_we;
	logic [SEM_W-1:0]        rec_waddr;
	rec_t                    rec_wdata;
	logic                    ring_we;
	logic                    ring_re;
	logic [SEM_W+Q_W-1:0]    ring_addr;
	logic                    alloc_inc;
	logic [1:0]              res_status;
	logic [3:0]              res_id;
	logic                    res_block;
	logic                    res_wake;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			proc_q     <= PID_BITS'(process);
			addr_q     <= SEM_W'(sem_index);
			init_q     <= init_value;
			in_range_q <= int'(sem_index) < NUM_SEMS;
			rec_rd_q   <= rec_mem[SEM_W'(sem_index)];
		end
	end

	assign alloc_full = alloc_cnt_q == ACNT_W'(NUM_SEMS);
	assign entry_live = in_range_q && (ACNT_W'(addr_q) < alloc_cnt_q);
	assign cnt_dec    = rec_rd_q.count - 16'sd1;
	assign cnt_inc    = (rec_rd_q.count < COUNT_MAX) ? rec_rd_q.count + 16'sd1 : rec_rd_q.count;

	always_comb begin
		rec_we     = 1'b0;
		rec_waddr  = addr_q;
		rec_wdata  = rec_rd_q;
		ring_we    = 1'b0;
		ring_re    = 1'b0;
		ring_addr  = {addr_q, rec_rd_q.tail};
		alloc_inc  = 1'b0;
		res_status = STATUS_OK;
		res_id     = '0;
		res_block  = 1'b0;
		res_wake   = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				if (alloc_full) begin
					res_status = STATUS_NO_FREE;
				end else begin
					rec_we          = 1'b1;
					rec_waddr       = alloc_cnt_q[SEM_W-1:0];
					rec_wdata.count = CNT_W'(init_q);
					rec_wdata.head  = '0;
					rec_wdata.tail  = '0;
					alloc_inc       = 1'b1;
					res_id          = 4'(alloc_cnt_q);
				end
			end
			KIND_WAIT: begin
				if (entry_live) begin
					if (rec_rd_q.count <= CNT_FLOOR) begin
						res_status = STATUS_Q_FULL;
					end else begin
						rec_we          = 1'b1;
						rec_wdata.count = cnt_dec;
						if (cnt_dec < 0) begin
							ring_we        = 1'b1;
							ring_addr      = {addr_q, rec_rd_q.tail};
							rec_wdata.tail = ptr_next(rec_rd_q.tail);
							res_block      = 1'b1;
						end
					end
				end
			end
			KIND_SIGNAL: begin
				if (entry_live) begin
					rec_we          = 1'b1;
					rec_wdata.count = cnt_inc;
					// a count not above zero means someone is queued
					if (cnt_inc <= 0) begin
						ring_re        = 1'b1;
						ring_addr      = {addr_q, rec_rd_q.head};
						rec_wdata.head = ptr_next(rec_rd_q.head);
						res_wake       = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && ring_we) begin
			ring_mem[ring_addr] <= proc_q;
		end
		if (cmd.exec && ring_re) begin
			ring_rd_q <= ring_mem[ring_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_cnt_q <= '0;
		end else if (cmd.exec && alloc_inc) begin
			alloc_cnt_q <= alloc_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= res_status;
			res_id_q     <= res_id;
			res_block_q  <= res_block;
			res_wake_q   <= res_wake;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q    <= res_status_q;
			sem_id_q    <= res_id_q;
			block_q     <= res_block_q;
			wake_q      <= res_wake_q;
			wake_proc_q <= res_wake_q ? 8'(ring_rd_q) : 8'd0;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign sem_id        = sem_id_q;
	assign block_caller  = block_q;
	assign wake_valid    = wake_q;
	assign wake_process  = wake_proc_q;

endmodule

// ===== rtl/counting_semaphore_table_unit.sv =====
// a request passes through a semaphore record read, then the record write-back with the wait-ring access,
// then the result register load, which waits while the result is stalled; a new request is taken only
// after the previous one has reached the result register
// reset: asynchronous, active low; clears the allocation count, the sequencer and the result
// valid; the record and ring memories need no clearing pass
module counting_semaphore_table_unit import csem_pkg::*; #(
	parameter int NUM_SEMS    = NUM_SEMS_DEF,
	parameter int MAX_WAITERS = MAX_WAITERS_DEF,
	parameter int PID_BITS    = PID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // process[7:0], sem_index[11:8], init_value[26:12]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // sem_id[3:0], block_caller[4], wake_valid[5],
	                                   // wake_process[13:6]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	cmd_t       cmd;
	sts_t       sts;
	logic [3:0] sem_id;
	logic       block_caller;
	logic       wake_valid;
	logic [7:0] wake_process;

	csem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	csem_datapath #(
		.NUM_SEMS    (NUM_SEMS),
		.MAX_WAITERS (MAX_WAITERS),
		.PID_BITS    (PID_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (s_axis_tuser),
		.process      (s_axis_tdata[7:0]),
		.sem_index    (s_axis_tdata[11:8]),
		.init_value   (s_axis_tdata[26:12]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.status       (m_axis_tuser),
		.sem_id       (sem_id),
		.block_caller (block_caller),
		.wake_valid   (wake_valid),
		.wake_process (wake_process)
	);

	assign m_axis_tdata = {2'b00, wake_process, wake_valid, block_caller, sem_id};

	// an accepted request always goes to execution next
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> cmd.exec)
		else $error("request accepted but not executed");

	// no new request while one is in flight
	a_exec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !s_axis_tready)
		else $error("ready while a request is in flight");

	// a wake-up only comes from a successful signal
	a_wake_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tuser == STATUS_OK && !m_axis_tdata[4])
		else $error("wake-up with bad status or block flag");

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import csem_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int N_REQ = 1600;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pid;
		logic [3:0]  sem;
		logic [14:0] init;
	} sem_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] sem_id;
		logic       block;
		logic       wake;
		logic [7:0] wake_pid;
	} sem_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // pid[7:0], sem_index[11:8], init_value[26:12]
	logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // sem_id[3:0], block_caller[4], wake_valid[5],
	                                 // wake_process[13:6]
	logic [1:0]  m_axis_tuser;       // status[1:0]

	counting_semaphore_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// predicted semaphore table
	bit         sem_used [NUM_SEMS_DEF];
	int         sem_cnt  [NUM_SEMS_DEF];
	int         ring_rd  [NUM_SEMS_DEF];
	int         ring_wr  [NUM_SEMS_DEF];
	logic [7:0] wait_ring [NUM_SEMS_DEF][MAX_WAITERS_DEF];

	sem_req_t req_backlog[$];
	sem_res_t result_due[$];

	// request generator's rough view of the table
	int gen_cnt [NUM_SEMS_DEF];
	int gen_alloc = 0;

	int  n_acc = 0;
	int  n_err = 0;
	int  n_res = 0;
	int  n_block = 0;
	int  n_wake = 0;
	int  n_qfull = 0;
	int  n_nofree = 0;
	logic hold_off = 1'b0;

	wire [1:0] phase = 2'((n_acc / 150) % 4);
	wire [6:0] send_idle_pct = (phase == 2'd1) ? 7'd84 : (phase == 2'd3) ? 7'd6 : 7'd0;
	wire [6:0] recv_stall_pct = (phase == 2'd2) ? 7'd84 : (phase == 2'd3) ? 7'd6 : 7'd0;

	function automatic sem_res_t sem_table_apply(sem_req_t r);
		sem_res_t o;
		int       s;
		o = '0;
		case (r.kind)
			KIND_ALLOC: begin
				s = NUM_SEMS_DEF;
				for (int i = NUM_SEMS_DEF - 1; i >= 0; i--)
					if (!sem_used[i]) s = i;
				if (s == NUM_SEMS_DEF) begin
					o.status = STATUS_NO_FREE;
				end else begin
					sem_used[s] = 1'b1;
					sem_cnt[s] = r.init;
					o.sem_id = s[3:0];
				end
			end
			KIND_WAIT: begin
				if (r.sem < NUM_SEMS_DEF && sem_used[r.sem]) begin
					if (sem_cnt[r.sem] <= -MAX_WAITERS_DEF) begin
						o.status = STATUS_Q_FULL;
					end else begin
						sem_cnt[r.sem]--;
						if (sem_cnt[r.sem] < 0) begin
							wait_ring[r.sem][ring_wr[r.sem]] =
								8'(r.pid & ((1 << PID_BITS_DEF) - 1));
							ring_wr[r.sem] = (ring_wr[r.sem] + 1) % MAX_WAITERS_DEF;
							o.block = 1'b1;
						end
					end
				end
			end
			KIND_SIGNAL: begin
				if (r.sem < NUM_SEMS_DEF && sem_used[r.sem]) begin
					if (sem_cnt[r.sem] < COUNT_MAX) sem_cnt[r.sem]++;
					// a count at or below zero means somebody is still queued
					if (sem_cnt[r.sem] <= 0) begin
						o.wake = 1'b1;
						o.wake_pid = wait_ring[r.sem][ring_rd[r.sem]];
						ring_rd[r.sem] = (ring_rd[r.sem] + 1) % MAX_WAITERS_DEF;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic queue_req(logic [1:0] kind, logic [7:0] pid, logic [3:0] sem,
	                         logic [14:0] init);
		sem_req_t r;
		r.kind = kind;
		r.pid = pid;
		r.sem = sem;
		r.init = init;
		req_backlog.push_back(r);
		if (kind == KIND_ALLOC && gen_alloc < NUM_SEMS_DEF) begin
			gen_cnt[gen_alloc] = init;
			gen_alloc++;
		end else if (kind == KIND_WAIT && sem < gen_alloc && gen_cnt[sem] > -MAX_WAITERS_DEF) begin
			gen_cnt[sem]--;
		end else if (kind == KIND_SIGNAL && sem < gen_alloc && gen_cnt[sem] < COUNT_MAX) begin
			gen_cnt[sem]++;
		end
	endtask

	// request driver
	always @(posedge clk) begin : drive_req
		sem_req_t nxt;
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = req_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {5'b0, nxt.init, nxt.sem, nxt.pid};
				s_axis_tuser <= nxt.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// accepted requests feed the predictor
	always @(posedge clk) begin : take_req
		sem_req_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r.kind = s_axis_tuser;
			r.pid = s_axis_tdata[7:0];
			r.sem = s_axis_tdata[11:8];
			r.init = s_axis_tdata[26:12];
			result_due.push_back(sem_table_apply(r));
			n_acc <= n_acc + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_res
		sem_res_t want;
		sem_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.sem_id = m_axis_tdata[3:0];
			got.block = m_axis_tdata[4];
			got.wake = m_axis_tdata[5];
			got.wake_pid = m_axis_tdata[13:6];
			if (result_due.size() == 0) begin
				$error("result with nothing outstanding: tdata %h tuser %h",
				       m_axis_tdata, m_axis_tuser);
				n_err++;
			end else begin
				want = result_due.pop_front();
				n_res++;
				if (want.block) n_block++;
				if (want.wake) n_wake++;
				if (want.status == STATUS_Q_FULL) n_qfull++;
				if (want.status == STATUS_NO_FREE) n_nofree++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					n_err++;
				end
				if (got.sem_id !== want.sem_id) begin
					$error("sem_id: expected %0d, got %0d", want.sem_id, got.sem_id);
					n_err++;
				end
				if (got.block !== want.block) begin
					$error("block_caller: expected %0d, got %0d", want.block, got.block);
					n_err++;
				end
				if (got.wake !== want.wake) begin
					$error("wake_valid: expected %0d, got %0d", want.wake, got.wake);
					n_err++;
				end
				if (got.wake_pid !== want.wake_pid) begin
					$error("wake_process: expected %0d, got %0d", want.wake_pid, got.wake_pid);
					n_err++;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up and drops s_axis_tready
	initial begin
		while (n_acc < 100) @(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#(20 * 400000);
		$display("testbench: errors");
		$finish;
	end

	initial begin : stim
		int       pick;
		int       sem;
		int       len;
		int       thresh;
		logic [1:0] k;
		// unknown kind and requests on free entries
		queue_req(KIND_NONE, 8'hFF, 4'hF, 15'h7FFF);
		queue_req(KIND_WAIT, 8'h12, 4'd3, 15'd0);
		queue_req(KIND_SIGNAL, 8'h34, 4'd15, 15'd0);
		// entry 0 sits at the count ceiling
		queue_req(KIND_ALLOC, 8'h00, 4'd0, 15'h7FFF);
		queue_req(KIND_SIGNAL, 8'h00, 4'd0, 15'd0);
		queue_req(KIND_WAIT, 8'h00, 4'd0, 15'd0);
		queue_req(KIND_SIGNAL, 8'hFF, 4'd0, 15'd0);
		queue_req(KIND_SIGNAL, 8'h00, 4'd0, 15'd0);
		// entry 1 starts empty: queue two waiters and release them in order
		queue_req(KIND_ALLOC, 8'hFF, 4'd0, 15'd0);
		queue_req(KIND_WAIT, 8'hFF, 4'd1, 15'd0);
		queue_req(KIND_WAIT, 8'h00, 4'd1, 15'h7FFF);
		queue_req(KIND_SIGNAL, 8'h00, 4'd1, 15'd0);
		queue_req(KIND_SIGNAL, 8'h00, 4'd1, 15'd0);
		queue_req(KIND_SIGNAL, 8'h00, 4'd1, 15'd0);
		queue_req(KIND_WAIT, 8'hA5, 4'd1, 15'd0);
		queue_req(KIND_WAIT, 8'h5A, 4'd1, 15'd0);
		queue_req(KIND_WAIT, 8'h3C, 4'd1, 15'd0);
		queue_req(KIND_SIGNAL, 8'h00, 4'd1, 15'd0);

		while (req_backlog.size() < N_REQ + 18) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				queue_req(KIND_ALLOC, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
				          ($urandom_range(0, 3) != 0) ? 15'($urandom_range(0, 3))
				                                      : 15'($urandom_range(0, 32767)));
			end else if (pick < 9) begin
				queue_req(KIND_NONE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
				          15'($urandom_range(0, 32767)));
			end else if (pick < 14) begin
				k = $urandom_range(0, 1) ? KIND_WAIT : KIND_SIGNAL;
				queue_req(k, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
				          15'($urandom_range(0, 32767)));
			end else begin
				// burst on one live semaphore, steered toward a full ring and back
				sem = $urandom_range(0, gen_alloc - 1);
				len = $urandom_range(1, 8);
				repeat (len) begin
					thresh = (gen_cnt[sem] > 0) ? 85 :
					         (gen_cnt[sem] <= -MAX_WAITERS_DEF) ? 30 : 55;
					k = ($urandom_range(0, 99) < thresh) ? KIND_WAIT : KIND_SIGNAL;
					queue_req(k, 8'($urandom_range(0, 255)), 4'(sem),
					          15'($urandom_range(0, 32767)));
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (req_backlog.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (result_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d requests, %0d results: %0d blocking waits, %0d wake-ups,",
		         n_acc, n_res, n_block, n_wake);
		$display("%0d waits on a full ring, %0d allocations with the table full",
		         n_qfull, n_nofree);
		if (n_err == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
